>>> hdl/xxh_pkg.sv
// Package for the xxHash64 stream block: primes, rotate helper, and the
// command and status types shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package xxh_pkg;

  localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

  localparam logic [5:0] STRIPE_BYTES = 6'd32;

  // Source of the multiplier's variable operand.
  typedef enum logic [2:0] {
    SRC_T,
    SRC_H,
    SRC_W,
    SRC_ACC,
    SRC_WLO,
    SRC_BYTE
  } mul_src_t;

  // Constant operand of the multiplier.
  typedef enum logic [2:0] {
    K_P1,
    K_P2,
    K_P3,
    K_P5
  } mul_const_t;

  // Destination of a multiplier result.
  typedef enum logic {
    DST_T,
    DST_H
  } mul_dst_t;

  // Datapath operations that do not use the multiplier.
  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_T_ACC_ROT,
    ALU_T_ROT31,
    ALU_ACC_STORE,
    ALU_H_CONVERGE,
    ALU_H_SHORT,
    ALU_H_TOTAL,
    ALU_H_XOR_T,
    ALU_H_ROT27,
    ALU_H_ROT23,
    ALU_H_ROT11,
    ALU_H_ADD_P4,
    ALU_H_ADD_P3,
    ALU_H_XSH33,
    ALU_H_XSH29,
    ALU_H_XSH32
  } alu_op_t;

  typedef struct packed {
    logic       load;
    logic       mul_start;
    mul_src_t   mul_src;
    mul_const_t mul_const;
    mul_dst_t   mul_dst;
    alu_op_t    alu;
    logic [1:0] sel;
    logic [5:0] off;
    logic       set_msg;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       full;
    logic       last;
    logic       had_stripe;
    logic [5:0] tail;
    logic       out_busy;
  } dp_status_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] const_of(input mul_const_t k);
    unique case (k)
      K_P1:    const_of = PRIME1;
      K_P2:    const_of = PRIME2;
      K_P3:    const_of = PRIME3;
      K_P5:    const_of = PRIME5;
      default: const_of = PRIME1;
    endcase
  endfunction

endpackage

>>> hdl/xxh_mul.sv
// Multi-cycle 64x64 multiplier keeping the low 64 bits of the product.
// Uses one 32x32 multiplier over three partial products. No dependencies.
`timescale 1ns / 1ps

module xxh_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] result,
  output logic        done
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LL,
    PH_LH,
    PH_HL,
    PH_SUM
  } phase_t;

  phase_t      phase;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod;
  logic [63:0] sum;
  logic [31:0] x;
  logic [31:0] y;

  // Pick the halves for the partial product of this phase.
  always_comb begin
    unique case (phase)
      PH_LH: begin
        x = a_r[31:0];
        y = b_r[63:32];
      end
      PH_HL: begin
        x = a_r[63:32];
        y = b_r[31:0];
      end
      default: begin
        x = a_r[31:0];
        y = b_r[31:0];
      end
    endcase
  end

  // Phase sequencer with registered partial product and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        phase <= PH_LL;
      end else begin
        unique case (phase)
          PH_LL: begin
            prod  <= x * y;
            phase <= PH_LH;
          end
          PH_LH: begin
            sum   <= prod;
            prod  <= x * y;
            phase <= PH_HL;
          end
          PH_HL: begin
            sum   <= sum + {prod[31:0], 32'd0};
            prod  <= x * y;
            phase <= PH_SUM;
          end
          PH_SUM: begin
            result <= sum + {prod[31:0], 32'd0};
            done   <= 1'b1;
            phase  <= PH_IDLE;
          end
          default: phase <= PH_IDLE;
        endcase
      end
    end
  end

endmodule

>>> hdl/xxh_datapath.sv
// Datapath of the xxHash64 stream block: lane accumulators, hash register,
// item words, byte total and the output register. Uses xxh_pkg and xxh_mul.
`timescale 1ns / 1ps

module xxh_datapath import xxh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [63:0] seed,
  input  logic [63:0] word_zero,
  input  logic [63:0] word_one,
  input  logic [63:0] word_two,
  input  logic [63:0] word_three,
  input  logic [5:0]  byte_count,
  input  logic        last_item,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [63:0] hash_value,
  output dp_status_t  status
);

  logic [63:0] w [4];
  logic [63:0] acc [4];
  logic [63:0] total;
  logic [63:0] t;
  logic [63:0] h;
  logic [5:0]  tail;
  logic        last;
  logic        had_stripe;
  logic        in_msg;
  mul_dst_t    dst;

  logic [5:0]  count_c;
  logic        full_c;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_res;
  logic        mul_done;
  logic [63:0] byte_word;

  // Clamp the count and decide whether the item is a whole stripe.
  always_comb begin
    count_c = (byte_count > STRIPE_BYTES) ? STRIPE_BYTES : byte_count;
    full_c  = !last_item || (count_c == STRIPE_BYTES);
  end

  // Multiplier operand selection.
  always_comb begin
    byte_word = w[cmd.off[4:3]] >> {cmd.off[2:0], 3'b000};
    unique case (cmd.mul_src)
      SRC_T:    mul_a = t;
      SRC_H:    mul_a = h;
      SRC_W:    mul_a = w[cmd.sel];
      SRC_ACC:  mul_a = acc[cmd.sel];
      SRC_WLO:  mul_a = {32'd0, w[cmd.sel][31:0]};
      SRC_BYTE: mul_a = {56'd0, byte_word[7:0]};
      default:  mul_a = t;
    endcase
    mul_b = const_of(cmd.mul_const);
  end

  xxh_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .result (mul_res),
    .done   (mul_done)
  );

  // The full flag follows the offered item so the controller can skip the
  // lane rounds for a short last item.
  always_comb begin
    status.mul_done   = mul_done;
    status.full       = full_c;
    status.last       = last;
    status.had_stripe = had_stripe;
    status.tail       = tail;
    status.out_busy   = out_valid && !out_ready;
  end

  // Control flags: message in progress and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.set_msg) begin
        in_msg <= 1'b1;
      end else if (cmd.out_load) begin
        in_msg <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, lane accumulators and hash arithmetic.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w[0]       <= word_zero;
      w[1]       <= word_one;
      w[2]       <= word_two;
      w[3]       <= word_three;
      last       <= last_item;
      tail       <= full_c ? 6'd0 : count_c;
      had_stripe <= in_msg || full_c;
      total      <= (in_msg ? total : 64'd0) + {58'd0, (full_c ? STRIPE_BYTES : count_c)};
      if (!in_msg) begin
        acc[0] <= seed + PRIME1 + PRIME2;
        acc[1] <= seed + PRIME2;
        acc[2] <= seed;
        acc[3] <= seed - PRIME1;
      end
    end
    if (cmd.mul_start) begin
      dst <= cmd.mul_dst;
    end
    if (mul_done) begin
      if (dst == DST_T) begin
        t <= mul_res;
      end else begin
        h <= mul_res;
      end
    end
    unique case (cmd.alu)
      ALU_T_ACC_ROT:  t <= rotl64(acc[cmd.sel] + t, 31);
      ALU_T_ROT31:    t <= rotl64(t, 31);
      ALU_ACC_STORE:  acc[cmd.sel] <= t;
      ALU_H_CONVERGE: h <= rotl64(acc[0], 1) + rotl64(acc[1], 7) +
                           rotl64(acc[2], 12) + rotl64(acc[3], 18);
      ALU_H_SHORT:    h <= seed + PRIME5;
      ALU_H_TOTAL:    h <= h + total;
      ALU_H_XOR_T:    h <= h ^ t;
      ALU_H_ROT27:    h <= rotl64(h, 27);
      ALU_H_ROT23:    h <= rotl64(h, 23);
      ALU_H_ROT11:    h <= rotl64(h, 11);
      ALU_H_ADD_P4:   h <= h + PRIME4;
      ALU_H_ADD_P3:   h <= h + PRIME3;
      ALU_H_XSH33:    h <= h ^ (h >> 33);
      ALU_H_XSH29:    h <= h ^ (h >> 29);
      ALU_H_XSH32:    h <= h ^ (h >> 32);
      default: ;
    endcase
    if (cmd.out_load) begin
      hash_value <= h;
    end
  end

endmodule

>>> hdl/xxh_ctrl.sv
// Controller of the xxHash64 stream block: sequences lane rounds, lane
// merging, tail folding and the avalanche. Uses xxh_pkg.
`timescale 1ns / 1ps

module xxh_ctrl import xxh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_WAIT,
    S_LN_MUL1,
    S_LN_ROT,
    S_LN_MUL2,
    S_LN_STORE,
    S_FIN,
    S_MG_MUL1,
    S_MG_ROT,
    S_MG_MUL2,
    S_MG_XOR,
    S_MG_ROTH,
    S_MG_MUL3,
    S_MG_ADD,
    S_TOTAL,
    S_TAIL,
    S_W4_MUL,
    S_W4_XOR,
    S_W4_ROT,
    S_W4_MUL2,
    S_W4_ADD,
    S_B_MUL,
    S_B_XOR,
    S_B_ROT,
    S_B_MUL2,
    S_AV1,
    S_AV2,
    S_AV3,
    S_AV4,
    S_AV5,
    S_OUT
  } state_t;

  state_t     state;
  state_t     ret;
  logic [1:0] idx;
  logic [5:0] off;
  logic       merging;
  logic [6:0] off8;
  logic [6:0] off4;
  logic [6:0] tail7;

  assign in_ready = (state == S_IDLE);
  assign off8     = {1'b0, off} + 7'd8;
  assign off4     = {1'b0, off} + 7'd4;
  assign tail7    = {1'b0, status.tail};

  // Command decode from the current state.
  always_comb begin
    cmd           = '0;
    cmd.mul_src   = SRC_T;
    cmd.mul_const = K_P1;
    cmd.mul_dst   = DST_T;
    cmd.alu       = ALU_NONE;
    cmd.off       = off;
    cmd.sel       = merging ? idx : off[4:3];
    unique case (state)
      S_IDLE:     cmd.load = in_valid;
      S_LN_MUL1: begin
        cmd.sel = idx;
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_W;
        cmd.mul_const = K_P2;
      end
      S_LN_ROT: begin
        cmd.sel = idx;
        cmd.alu = ALU_T_ACC_ROT;
      end
      S_LN_MUL2:  cmd.mul_start = 1'b1;
      S_LN_STORE: begin
        cmd.sel     = idx;
        cmd.alu     = ALU_ACC_STORE;
        cmd.set_msg = (idx == 2'd3) && !status.last;
      end
      S_FIN:      cmd.alu = status.had_stripe ? ALU_H_CONVERGE : ALU_H_SHORT;
      S_MG_MUL1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = merging ? SRC_ACC : SRC_W;
        cmd.mul_const = K_P2;
      end
      S_MG_ROT:   cmd.alu = ALU_T_ROT31;
      S_MG_MUL2:  cmd.mul_start = 1'b1;
      S_MG_XOR:   cmd.alu = ALU_H_XOR_T;
      S_MG_ROTH:  cmd.alu = ALU_H_ROT27;
      S_MG_MUL3: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_H;
        cmd.mul_dst   = DST_H;
      end
      S_MG_ADD:   cmd.alu = ALU_H_ADD_P4;
      S_TOTAL:    cmd.alu = ALU_H_TOTAL;
      S_W4_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_WLO;
      end
      S_W4_XOR:   cmd.alu = ALU_H_XOR_T;
      S_W4_ROT:   cmd.alu = ALU_H_ROT23;
      S_W4_MUL2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_H;
        cmd.mul_const = K_P2;
        cmd.mul_dst   = DST_H;
      end
      S_W4_ADD:   cmd.alu = ALU_H_ADD_P3;
      S_B_MUL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_BYTE;
        cmd.mul_const = K_P5;
      end
      S_B_XOR:    cmd.alu = ALU_H_XOR_T;
      S_B_ROT:    cmd.alu = ALU_H_ROT11;
      S_B_MUL2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_H;
        cmd.mul_dst   = DST_H;
      end
      S_AV1:      cmd.alu = ALU_H_XSH33;
      S_AV2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_H;
        cmd.mul_const = K_P2;
        cmd.mul_dst   = DST_H;
      end
      S_AV3:      cmd.alu = ALU_H_XSH29;
      S_AV4: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = SRC_H;
        cmd.mul_const = K_P3;
        cmd.mul_dst   = DST_H;
      end
      S_AV5:      cmd.alu = ALU_H_XSH32;
      S_OUT:      cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

  // State, return state and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      idx     <= 2'd0;
      off     <= 6'd0;
      merging <= 1'b0;
    end else begin
      unique case (state)
        // A short last item skips the lane rounds and goes straight to the finish.
        S_IDLE: begin
          if (in_valid) begin
            idx     <= 2'd0;
            merging <= 1'b0;
            state   <= status.full ? S_LN_MUL1 : S_FIN;
          end
        end
        S_WAIT:     if (status.mul_done) state <= ret;
        S_LN_MUL1: begin
          ret   <= S_LN_ROT;
          state <= S_WAIT;
        end
        S_LN_ROT:   state <= S_LN_MUL2;
        S_LN_MUL2: begin
          ret   <= S_LN_STORE;
          state <= S_WAIT;
        end
        S_LN_STORE: begin
          idx <= idx + 2'd1;
          if (idx != 2'd3) begin
            state <= S_LN_MUL1;
          end else if (status.last) begin
            state <= S_FIN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FIN: begin
          idx     <= 2'd0;
          merging <= status.had_stripe;
          state   <= status.had_stripe ? S_MG_MUL1 : S_TOTAL;
        end
        S_MG_MUL1: begin
          ret   <= S_MG_ROT;
          state <= S_WAIT;
        end
        S_MG_ROT:   state <= S_MG_MUL2;
        S_MG_MUL2: begin
          ret   <= S_MG_XOR;
          state <= S_WAIT;
        end
        S_MG_XOR:   state <= merging ? S_MG_MUL3 : S_MG_ROTH;
        S_MG_ROTH:  state <= S_MG_MUL3;
        S_MG_MUL3: begin
          ret   <= S_MG_ADD;
          state <= S_WAIT;
        end
        S_MG_ADD: begin
          if (merging) begin
            idx   <= idx + 2'd1;
            state <= (idx == 2'd3) ? S_TOTAL : S_MG_MUL1;
          end else begin
            off   <= off8[5:0];
            state <= S_TAIL;
          end
        end
        S_TOTAL: begin
          merging <= 1'b0;
          off     <= 6'd0;
          state   <= S_TAIL;
        end
        // Tail folding: 8-byte words, then at most one 4-byte word, then bytes.
        S_TAIL: begin
          priority if (off8 <= tail7) begin
            state <= S_MG_MUL1;
          end else if (off4 <= tail7) begin
            state <= S_W4_MUL;
          end else if (off < status.tail) begin
            state <= S_B_MUL;
          end else begin
            state <= S_AV1;
          end
        end
        S_W4_MUL: begin
          ret   <= S_W4_XOR;
          state <= S_WAIT;
        end
        S_W4_XOR:   state <= S_W4_ROT;
        S_W4_ROT:   state <= S_W4_MUL2;
        S_W4_MUL2: begin
          ret   <= S_W4_ADD;
          state <= S_WAIT;
        end
        S_W4_ADD: begin
          off   <= off4[5:0];
          state <= S_TAIL;
        end
        S_B_MUL: begin
          ret   <= S_B_XOR;
          state <= S_WAIT;
        end
        S_B_XOR:    state <= S_B_ROT;
        S_B_ROT:    state <= S_B_MUL2;
        S_B_MUL2: begin
          off   <= off + 6'd1;
          ret   <= S_TAIL;
          state <= S_WAIT;
        end
        S_AV1:      state <= S_AV2;
        S_AV2: begin
          ret   <= S_AV3;
          state <= S_WAIT;
        end
        S_AV3:      state <= S_AV4;
        S_AV4: begin
          ret   <= S_AV5;
          state <= S_WAIT;
        end
        S_AV5:      state <= S_OUT;
        S_OUT:      if (!status.out_busy) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/xxhash64_stream.sv
// xxHash64 over a stream of 32-byte items; APB seed register, controller and datapath (xxh_pkg).
// Each 64-bit product runs on a shared 32x32 multiplier. A full item takes four lane rounds.
// A last item adds lane merging when a stripe was seen, a round per 8-byte tail word, one
// for the 4-byte word, one per tail byte and the avalanche. One item is in work at a time.
// Reset (synchronous, active high) clears the seed, message state and output valid flag.
`timescale 1ns / 1ps

module xxhash64_stream import xxh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] word_zero,
  input  logic [63:0] word_one,
  input  logic [63:0] word_two,
  input  logic [63:0] word_three,
  input  logic [5:0]  byte_count,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  localparam logic [3:0] ADDR_SEED = 4'h0;

  logic [63:0] seed;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;

  // Seed register on the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 64'd0;
    end else if (psel && penable && pwrite && (paddr == ADDR_SEED)) begin
      seed <= pwdata;
    end
  end

  assign prdata = (paddr == ADDR_SEED) ? seed : 64'd0;

  xxh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  xxh_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .seed       (seed),
    .word_zero  (word_zero),
    .word_one   (word_one),
    .word_two   (word_two),
    .word_three (word_three),
    .byte_count (byte_count),
    .last_item  (last_item),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .hash_value (hash_value),
    .status     (status)
  );

endmodule
